FILE: src/sgtb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgtb_pkg;

    localparam int MAX_TRB_DATA    = 65536;
    localparam int MAX_ENTRY_BYTES = 1048576;

    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_SETUP  = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0] XFER_CONTROL = 2'd0;
    localparam logic [1:0] XFER_BULK    = 2'd1;
    localparam logic [1:0] XFER_ISOC    = 2'd2;

    localparam logic [1:0] STYPE_NONE = 2'd0;
    localparam logic [1:0] STYPE_OUT  = 2'd1;
    localparam logic [1:0] STYPE_IN   = 2'd2;

    localparam logic [2:0] REG_KIND  = 3'd0;
    localparam logic [2:0] REG_DIR   = 3'd1;
    localparam logic [2:0] REG_MPS   = 3'd2;
    localparam logic [2:0] REG_TLEN  = 3'd3;
    localparam logic [2:0] REG_SOFF  = 3'd4;
    localparam logic [2:0] REG_SETUP = 3'd5;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_SETUP,
        EM_CHUNK,
        EM_ZLP,
        EM_STATUS,
        EM_TRAIL,
        EM_SHORT
    } t_emit;

    typedef struct packed {
        logic  accept;
        logic  set_done;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic done;
        logic phase0;
        logic ctrl;
        logic isoc;
        logic bytes_zero;
        logic more;
        logic fin;
        logic zlp;
        logic final_entry;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/sgtb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sgtb_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data,
    input  wire logic [63:0]   i_entry_address,
    input  wire logic [20:0]   i_entry_length,
    input  wire logic          i_final_entry,
    input  wire logic          i_out_ready,
    input  wire sgtb_pkg::t_cmd i_cmd,
    output sgtb_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output logic [63:0]        o_trb_pointer,
    output logic [16:0]        o_trb_length,
    output logic [1:0]         o_trb_kind,
    output logic               o_dir_in_flag,
    output logic               o_chain_flag,
    output logic               o_ioc_flag,
    output logic               o_isp_flag,
    output logic               o_idt_flag,
    output logic [1:0]         o_stage_type_field,
    output logic               o_last_element,
    output logic               o_list_short
);

    logic [1:0]  r_kind, n_kind;
    logic        r_dir, n_dir;
    logic [10:0] r_mps, n_mps;
    logic [23:0] r_tlen, n_tlen;
    logic [31:0] r_soff, n_soff;
    logic [63:0] r_setup, n_setup;
    logic        cfg_hit;

    logic [23:0] r_bytes;
    logic [31:0] r_skip;
    logic        r_phase;
    logic        r_done;

    logic [63:0] r_addr;
    logic [20:0] r_len;
    logic [20:0] r_off;
    logic        r_final;

    logic        r_out_valid;
    logic [63:0] r_ptr, n_ptr;
    logic [16:0] r_olen, n_olen;
    logic [1:0]  r_okind, n_okind;
    logic        r_odir, r_chain, r_ioc, r_isp, r_idt, r_last, r_short;
    logic        n_odir, n_chain, n_ioc, n_isp, n_idt, n_last, n_short;
    logic [1:0]  r_stype, n_stype;

    logic        ctrl, isoc, slot_free;
    logic [20:0] clamp_len;
    logic [20:0] rem_e;
    logic [23:0] c1;
    logic [16:0] chunk;
    logic        fin, zlp, more, nc_last, ack_in;
    logic [63:0] chunk_ptr;

    always_comb begin
        n_kind  = r_kind;
        n_dir   = r_dir;
        n_mps   = r_mps;
        n_tlen  = r_tlen;
        n_soff  = r_soff;
        n_setup = r_setup;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            cfg_hit = 1'b1;
            unique case (i_cfg_index)
                sgtb_pkg::REG_KIND:  n_kind  = i_cfg_data[1:0];
                sgtb_pkg::REG_DIR:   n_dir   = i_cfg_data[0];
                sgtb_pkg::REG_MPS:   n_mps   = i_cfg_data[10:0];
                sgtb_pkg::REG_TLEN:  n_tlen  = i_cfg_data[23:0];
                sgtb_pkg::REG_SOFF:  n_soff  = i_cfg_data[31:0];
                sgtb_pkg::REG_SETUP: n_setup = i_cfg_data;
                default:             cfg_hit = 1'b0;
            endcase
        end
    end

    assign ctrl      = r_kind == sgtb_pkg::XFER_CONTROL;
    assign isoc      = r_kind == sgtb_pkg::XFER_ISOC;
    assign slot_free = !r_out_valid || i_out_ready;
    assign clamp_len = (i_entry_length > 21'(sgtb_pkg::MAX_ENTRY_BYTES))
                     ? 21'(sgtb_pkg::MAX_ENTRY_BYTES) : i_entry_length;

    // chunk: least of entry bytes left, transfer bytes left and descriptor limit
    assign rem_e     = r_len - r_off;
    assign c1        = ({3'b0, rem_e} > r_bytes) ? r_bytes : {3'b0, rem_e};
    assign chunk     = (c1 > 24'(sgtb_pkg::MAX_TRB_DATA))
                     ? 17'(sgtb_pkg::MAX_TRB_DATA) : c1[16:0];
    assign fin       = r_bytes == {7'b0, chunk};
    assign zlp       = fin && !isoc && !r_dir && ({6'b0, r_mps} == chunk);
    assign more      = (r_off < r_len) && (r_bytes != 24'd0);
    assign nc_last   = fin && !isoc && !zlp;
    assign ack_in    = !((r_tlen > 24'd8) && r_dir);
    assign chunk_ptr = r_addr + {43'b0, r_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= sgtb_pkg::XFER_BULK;
            r_dir       <= 1'b0;
            r_mps       <= 11'd512;
            r_tlen      <= 24'd0;
            r_soff      <= 32'd0;
            r_setup     <= 64'd0;
            r_bytes     <= 24'd0;
            r_skip      <= 32'd0;
            r_phase     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_kind  <= n_kind;
            r_dir   <= n_dir;
            r_mps   <= n_mps;
            r_tlen  <= n_tlen;
            r_soff  <= n_soff;
            r_setup <= n_setup;
            if (!cfg_hit && i_cmd.emit != sgtb_pkg::EM_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_hit) begin
                if (n_kind == sgtb_pkg::XFER_CONTROL) begin
                    r_bytes <= (n_tlen >= 24'd8) ? n_tlen - 24'd8 : 24'd0;
                    r_skip  <= n_soff + 32'd8;
                end else begin
                    r_bytes <= n_tlen;
                    r_skip  <= n_soff;
                end
                r_phase <= 1'b0;
                r_done  <= 1'b0;
            end else begin
                if (i_cmd.accept) begin
                    r_phase <= 1'b1;
                    if (r_skip >= {11'b0, clamp_len}) begin
                        r_skip <= r_skip - {11'b0, clamp_len};
                        r_off  <= clamp_len;
                    end else begin
                        r_skip <= 32'd0;
                        r_off  <= r_skip[20:0];
                    end
                end
                if (i_cmd.set_done) begin
                    r_done <= 1'b1;
                end
                if (i_cmd.emit == sgtb_pkg::EM_CHUNK) begin
                    r_bytes <= r_bytes - {7'b0, chunk};
                    r_off   <= r_off + {4'b0, chunk};
                end
            end
        end
    end

    always_comb begin
        n_ptr   = 64'd0;
        n_olen  = 17'd0;
        n_okind = sgtb_pkg::KIND_NORMAL;
        n_odir  = 1'b0;
        n_chain = 1'b0;
        n_ioc   = 1'b0;
        n_isp   = 1'b0;
        n_idt   = 1'b0;
        n_stype = sgtb_pkg::STYPE_NONE;
        n_last  = 1'b0;
        n_short = 1'b0;
        unique case (i_cmd.emit)
            sgtb_pkg::EM_SETUP: begin
                n_ptr   = r_setup;
                n_olen  = 17'd8;
                n_okind = sgtb_pkg::KIND_SETUP;
                n_chain = 1'b1;
                n_idt   = 1'b1;
                if (r_bytes != 24'd0) begin
                    n_stype = r_dir ? sgtb_pkg::STYPE_IN : sgtb_pkg::STYPE_OUT;
                end
            end
            sgtb_pkg::EM_CHUNK: begin
                n_ptr  = chunk_ptr;
                n_olen = chunk;
                n_isp  = 1'b1;
                if (ctrl) begin
                    n_okind = sgtb_pkg::KIND_DATA;
                    n_odir  = r_dir;
                    n_chain = 1'b1;
                end else begin
                    n_chain = !nc_last;
                    n_ioc   = nc_last;
                    n_last  = nc_last;
                end
            end
            sgtb_pkg::EM_ZLP: begin
                n_okind = sgtb_pkg::KIND_DATA;
                n_chain = 1'b1;
                n_isp   = 1'b1;
            end
            sgtb_pkg::EM_STATUS: begin
                n_okind = sgtb_pkg::KIND_STATUS;
                n_odir  = ack_in;
                n_ioc   = 1'b1;
                n_last  = 1'b1;
            end
            sgtb_pkg::EM_TRAIL: begin
                n_ioc  = 1'b1;
                n_isp  = 1'b1;
                n_last = 1'b1;
            end
            sgtb_pkg::EM_SHORT: begin
                n_short = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr  <= i_entry_address;
            r_len   <= clamp_len;
            r_final <= i_final_entry;
        end
        if (i_cmd.emit != sgtb_pkg::EM_NONE) begin
            r_ptr   <= n_ptr;
            r_olen  <= n_olen;
            r_okind <= n_okind;
            r_odir  <= n_odir;
            r_chain <= n_chain;
            r_ioc   <= n_ioc;
            r_isp   <= n_isp;
            r_idt   <= n_idt;
            r_stype <= n_stype;
            r_last  <= n_last;
            r_short <= n_short;
        end
    end

    always_comb begin
        o_sts.slot_free   = slot_free;
        o_sts.done        = r_done;
        o_sts.phase0      = !r_phase;
        o_sts.ctrl        = ctrl;
        o_sts.isoc        = isoc;
        o_sts.bytes_zero  = r_bytes == 24'd0;
        o_sts.more        = more;
        o_sts.fin         = fin;
        o_sts.zlp         = zlp;
        o_sts.final_entry = r_final;
    end

    assign o_out_valid        = r_out_valid;
    assign o_trb_pointer      = r_ptr;
    assign o_trb_length       = r_olen;
    assign o_trb_kind         = r_okind;
    assign o_dir_in_flag      = r_odir;
    assign o_chain_flag       = r_chain;
    assign o_ioc_flag         = r_ioc;
    assign o_isp_flag         = r_isp;
    assign o_idt_flag         = r_idt;
    assign o_stage_type_field = r_stype;
    assign o_last_element     = r_last;
    assign o_list_short       = r_short;

endmodule
`default_nettype wire

FILE: src/sgtb_controller.sv
`timescale 1ns / 1ps
`default_nettype none
module sgtb_controller (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire sgtb_pkg::t_sts i_sts,
    output logic                o_in_ready,
    output sgtb_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHUNK,
        ST_ZLP,
        ST_STATUS,
        ST_TRAIL,
        ST_SHORT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.set_done = 1'b0;
        o_cmd.emit     = sgtb_pkg::EM_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_sts.done) begin
                        if (i_sts.phase0 && i_sts.ctrl) begin
                            n_state = ST_SETUP;
                        end else if (i_sts.phase0 && i_sts.bytes_zero) begin
                            o_cmd.set_done = 1'b1;
                        end else begin
                            n_state = ST_CHUNK;
                        end
                    end
                end
            end
            ST_SETUP: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = sgtb_pkg::EM_SETUP;
                    n_state    = i_sts.bytes_zero ? ST_STATUS : ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                if (!i_sts.more) begin
                    n_state = i_sts.final_entry ? ST_SHORT : ST_IDLE;
                end else if (i_sts.slot_free) begin
                    o_cmd.emit = sgtb_pkg::EM_CHUNK;
                    if (i_sts.fin) begin
                        if (i_sts.ctrl) begin
                            n_state = i_sts.zlp ? ST_ZLP : ST_STATUS;
                        end else if (i_sts.isoc || i_sts.zlp) begin
                            n_state = ST_TRAIL;
                        end else begin
                            o_cmd.set_done = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end
                end
            end
            ST_ZLP: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = sgtb_pkg::EM_ZLP;
                    n_state    = ST_STATUS;
                end
            end
            ST_STATUS, ST_TRAIL, ST_SHORT: begin
                if (i_sts.slot_free) begin
                    priority if (r_state == ST_STATUS) begin
                        o_cmd.emit = sgtb_pkg::EM_STATUS;
                    end else if (r_state == ST_TRAIL) begin
                        o_cmd.emit = sgtb_pkg::EM_TRAIL;
                    end else begin
                        o_cmd.emit = sgtb_pkg::EM_SHORT;
                    end
                    o_cmd.set_done = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == ST_IDLE;

endmodule
`default_nettype wire

FILE: src/sg_transfer_trb_builder.sv
// scatter-gather to transfer descriptor builder
// configuration: write port (i_cfg_we, i_cfg_index, i_cfg_data), the user writes
//   only while idle (unenforced); index 0-5 writes restart with the new settings
// input channel: one scatter-gather entry per item (valid/ready)
// output channel: one transfer descriptor per item (valid/ready), held in an
//   output register so the builder moves on while a descriptor waits
// an entry is taken while the sequencer is idle, then its descriptors are
//   produced one per cycle by the sequencer while the output register has
//   room; an entry yields up to 19 descriptors, and the input side stays
//   busy until the sequencer is done with the entry
// first descriptor is emitted by the state entered on acceptance, then registered
// receiver stall: the sequencer holds while the output register is full; no
//   descriptor is lost and no new entry is taken until the current one ends
// reset: registers return to defaults (bulk, out, max packet 512, length 0),
//   no transfer in progress; entries after the transfer ends produce nothing
`timescale 1ns / 1ps
`default_nettype none
module sg_transfer_trb_builder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_entry_address,
    input  wire logic [20:0] i_entry_length,
    input  wire logic        i_final_entry,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_trb_pointer,
    output logic [16:0]      o_trb_length,
    output logic [1:0]       o_trb_kind,
    output logic             o_dir_in_flag,
    output logic             o_chain_flag,
    output logic             o_ioc_flag,
    output logic             o_isp_flag,
    output logic             o_idt_flag,
    output logic [1:0]       o_stage_type_field,
    output logic             o_last_element,
    output logic             o_list_short
);

    sgtb_pkg::t_cmd cmd;
    sgtb_pkg::t_sts sts;

    sgtb_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sgtb_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_entry_address    (i_entry_address),
        .i_entry_length     (i_entry_length),
        .i_final_entry      (i_final_entry),
        .i_out_ready        (i_out_ready),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_trb_pointer      (o_trb_pointer),
        .o_trb_length       (o_trb_length),
        .o_trb_kind         (o_trb_kind),
        .o_dir_in_flag      (o_dir_in_flag),
        .o_chain_flag       (o_chain_flag),
        .o_ioc_flag         (o_ioc_flag),
        .o_isp_flag         (o_isp_flag),
        .o_idt_flag         (o_idt_flag),
        .o_stage_type_field (o_stage_type_field),
        .o_last_element     (o_last_element),
        .o_list_short       (o_list_short)
    );

endmodule
`default_nettype wire
